// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: rtl/encbal_pkg.sv
// Types, register indexes, action codes and fixed widths for the encoder balance PID.
// Depends on nothing; used by the top level and its checker.
package encbal_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int REG_IDX_W  = 3;
  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 8;
  localparam int ACTION_W   = 2;
  localparam int SUM_W      = 32;
  localparam int CORR_W     = 11;

  typedef logic [REG_IDX_W-1:0]      reg_idx_t;
  typedef logic [ACTION_W-1:0]       action_t;
  typedef logic signed [GAIN_W-1:0]  gain_t;
  typedef logic [DRIVE_W-1:0]        drive_t;
  typedef logic signed [CORR_W-1:0]  corr_t;

  localparam reg_idx_t REG_PROP_GAIN  = 3'd0;
  localparam reg_idx_t REG_INTEG_GAIN = 3'd1;
  localparam reg_idx_t REG_DERIV_GAIN = 3'd2;
  localparam reg_idx_t REG_BASE_DRIVE = 3'd3;
  localparam reg_idx_t REG_MIN_DRIVE  = 3'd4;
  localparam reg_idx_t REG_MAX_DRIVE  = 3'd5;

  localparam action_t ACT_LEFT  = 2'd0;
  localparam action_t ACT_RIGHT = 2'd1;
  localparam action_t ACT_TICK  = 2'd2;

  localparam gain_t  PROP_GAIN_RST  = 16'sd384;
  localparam gain_t  INTEG_GAIN_RST = 16'sd0;
  localparam gain_t  DERIV_GAIN_RST = 16'sd0;
  localparam drive_t BASE_DRIVE_RST = 8'd65;
  localparam drive_t MIN_DRIVE_RST  = 8'd50;
  localparam drive_t MAX_DRIVE_RST  = 8'd255;

  localparam corr_t CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam corr_t CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

endpackage

// File: rtl/encoder_balance_pid.sv
// Encoder balance PID: quadrature tick counters, PID on left minus right, clamped drives.
// Depends on encbal_pkg.
//
//   channel | signals                                  | beat when
//   cfg     | cfg_wen, cfg_index, cfg_data             | cfg_wen high
//   in      | in_valid, in_ready, action, phase_a/b    | in_valid && in_ready
//   out     | out_valid, out_ready, left/right_drive   | out_valid && out_ready
//
// One input beat per cycle while in_ready is high; edge events update the counts
// at accept and give no beat. A control tick goes through s1 to s4 and the output register:
// error, integral, derivative, three gain products, their sum, truncated correction, clamp.
// Reset (rst, synchronous) clears counts, integral, last error, stages; loads all defaults.
// A stalled output fills the stages behind it; in_ready drops only when all are full.
module encoder_balance_pid #(
  parameter int COUNT_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [encbal_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [encbal_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [encbal_pkg::ACTION_W-1:0]   action,
  input  logic                           phase_a,
  input  logic                           phase_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [encbal_pkg::DRIVE_W-1:0]    left_drive,
  output logic [encbal_pkg::DRIVE_W-1:0]    right_drive
);
  import encbal_pkg::*;

  localparam int EW  = COUNT_WIDTH + 1;
  localparam int DW  = COUNT_WIDTH + 2;
  localparam int XW  = ((EW > SUM_W) ? EW : SUM_W) + 1;
  localparam int PPW = GAIN_W + EW;
  localparam int PIW = GAIN_W + SUM_W;
  localparam int PDW = GAIN_W + DW;
  localparam int ACW = ((DW > SUM_W) ? DW : SUM_W) + GAIN_W + 2;
  localparam int CRW = ACW - GAIN_FRAC_BITS;
  localparam int XDW = CORR_W + 1;

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [XW-1:0] SUM_HI = {{(XW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [XW-1:0] SUM_LO = {{(XW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
  localparam logic [ACW-1:0] TRUNC_BIAS =
    {{(ACW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

  // configuration registers
  gain_t  prop_gain, integ_gain, deriv_gain;
  drive_t base_drive, min_drive, max_drive;

  // counter and controller state
  logic signed [COUNT_WIDTH-1:0] left_ticks, right_ticks;
  logic signed [COUNT_WIDTH-1:0] left_ticks_next, right_ticks_next;
  logic signed [SUM_W-1:0]       error_sum, error_sum_next;
  logic signed [EW-1:0]          last_error;

  // pipeline stages
  logic                   s1_valid, s2_valid, s3_valid, s4_valid;
  logic signed [EW-1:0]   s1_err;
  logic signed [SUM_W-1:0] s1_sum;
  logic signed [DW-1:0]   s1_deriv;
  logic signed [PPW-1:0]  s2_prop;
  logic signed [PIW-1:0]  s2_integ;
  logic signed [PDW-1:0]  s2_deriv;
  logic signed [ACW-1:0]  s3_acc;
  corr_t                  s4_corr;

  logic in_fire, is_tick;
  logic o_free, s4_free, s3_free, s2_free, s1_free;

  logic signed [EW-1:0]  err;
  logic signed [DW-1:0]  deriv;
  logic signed [XW-1:0]  sum_x;
  logic signed [PPW-1:0] prop_prod;
  logic signed [PIW-1:0] integ_prod;
  logic signed [PDW-1:0] deriv_prod;
  logic signed [ACW-1:0] acc_sum;
  logic [ACW-1:0]        acc_biased;
  logic signed [CRW-1:0] corr_full;
  logic [CRW-CORR_W:0]   corr_top;
  corr_t                 corr_sat;
  logic signed [XDW-1:0] base_x, corr_x, left_x, right_x;

  function automatic logic signed [COUNT_WIDTH-1:0] count_step(
    input logic signed [COUNT_WIDTH-1:0] c,
    input logic                          up
  );
    logic signed [COUNT_WIDTH-1:0] r;
    r = c;
    if (up) begin
      if (c != CNT_MAX) r = c + 1'b1;
    end else begin
      if (c != CNT_MIN) r = c - 1'b1;
    end
    return r;
  endfunction

  function automatic drive_t clamp_drive(
    input logic signed [XDW-1:0] x,
    input drive_t                lo,
    input drive_t                hi
  );
    logic signed [XDW-1:0] lo_x, hi_x;
    drive_t r;
    lo_x = {{(XDW-DRIVE_W){1'b0}}, lo};
    hi_x = {{(XDW-DRIVE_W){1'b0}}, hi};
    if (x < lo_x)      r = lo;
    else if (x > hi_x) r = hi;
    else               r = x[DRIVE_W-1:0];
    return r;
  endfunction

  // handshake: free when empty or when the content moves on
  assign o_free   = !out_valid || out_ready;
  assign s4_free  = !s4_valid || o_free;
  assign s3_free  = !s3_valid || s4_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;
  assign is_tick  = (action == ACT_TICK);

  // counters, error, integral, derivative
  assign left_ticks_next  = count_step(left_ticks, phase_a == phase_b);
  assign right_ticks_next = count_step(right_ticks, phase_a == phase_b);
  assign err   = {left_ticks[COUNT_WIDTH-1], left_ticks}
               - {right_ticks[COUNT_WIDTH-1], right_ticks};
  assign deriv = {err[EW-1], err} - {last_error[EW-1], last_error};
  assign sum_x = {{(XW-EW){err[EW-1]}}, err}
               + {{(XW-SUM_W){error_sum[SUM_W-1]}}, error_sum};

  always_comb begin
    if (sum_x > SUM_HI)      error_sum_next = SUM_HI[SUM_W-1:0];
    else if (sum_x < SUM_LO) error_sum_next = SUM_LO[SUM_W-1:0];
    else                     error_sum_next = sum_x[SUM_W-1:0];
  end

  // gains times terms
  assign prop_prod  = prop_gain * s1_err;
  assign integ_prod = integ_gain * s1_sum;
  assign deriv_prod = deriv_gain * s1_deriv;

  assign acc_sum = {{(ACW-PPW){s2_prop[PPW-1]}}, s2_prop}
                 + {{(ACW-PIW){s2_integ[PIW-1]}}, s2_integ}
                 + {{(ACW-PDW){s2_deriv[PDW-1]}}, s2_deriv};

  // divide by the gain scale, truncating toward zero, then saturate
  assign acc_biased = s3_acc + (s3_acc[ACW-1] ? TRUNC_BIAS : {ACW{1'b0}});
  assign corr_full  = acc_biased[ACW-1:GAIN_FRAC_BITS];
  assign corr_top   = corr_full[CRW-1:CORR_W-1];

  always_comb begin
    if ((&corr_top) || !(|corr_top)) corr_sat = corr_full[CORR_W-1:0];
    else if (corr_full[CRW-1])       corr_sat = CORR_MIN;
    else                             corr_sat = CORR_MAX;
  end

  assign base_x  = {{(XDW-DRIVE_W){1'b0}}, base_drive};
  assign corr_x  = {s4_corr[CORR_W-1], s4_corr};
  assign left_x  = base_x - corr_x;
  assign right_x = base_x + corr_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= PROP_GAIN_RST;
      integ_gain <= INTEG_GAIN_RST;
      deriv_gain <= DERIV_GAIN_RST;
      base_drive <= BASE_DRIVE_RST;
      min_drive  <= MIN_DRIVE_RST;
      max_drive  <= MAX_DRIVE_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= gain_t'(cfg_data);
        REG_INTEG_GAIN: integ_gain <= gain_t'(cfg_data);
        REG_DERIV_GAIN: deriv_gain <= gain_t'(cfg_data);
        REG_BASE_DRIVE: base_drive <= cfg_data[DRIVE_W-1:0];
        REG_MIN_DRIVE:  min_drive  <= cfg_data[DRIVE_W-1:0];
        REG_MAX_DRIVE:  max_drive  <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_ticks  <= '0;
      right_ticks <= '0;
      error_sum   <= '0;
      last_error  <= '0;
    end else if (in_fire) begin
      case (action)
        ACT_LEFT:  left_ticks  <= left_ticks_next;
        ACT_RIGHT: right_ticks <= right_ticks_next;
        ACT_TICK: begin
          left_ticks  <= '0;
          right_ticks <= '0;
          error_sum   <= error_sum_next;
          last_error  <= err;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid  <= in_fire && is_tick;
      if (s2_free) s2_valid  <= s1_valid;
      if (s3_free) s3_valid  <= s2_valid;
      if (s4_free) s4_valid  <= s3_valid;
      if (o_free)  out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_fire && is_tick) begin
      s1_err   <= err;
      s1_sum   <= error_sum_next;
      s1_deriv <= deriv;
    end
    if (s2_free) begin
      s2_prop  <= prop_prod;
      s2_integ <= integ_prod;
      s2_deriv <= deriv_prod;
    end
    if (s3_free) s3_acc  <= acc_sum;
    if (s4_free) s4_corr <= corr_sat;
    if (o_free) begin
      left_drive  <= clamp_drive(left_x, min_drive, max_drive);
      right_drive <= clamp_drive(right_x, min_drive, max_drive);
    end
  end

endmodule

// File: rtl/encbal_checker.sv
// Port-level checks for encoder_balance_pid, bound to the top level below.
// Depends on encbal_pkg and assert_macros.svh.
`include "assert_macros.svh"

module encbal_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [encbal_pkg::DRIVE_W-1:0]  left_drive,
  input logic [encbal_pkg::DRIVE_W-1:0]  right_drive
);
  import encbal_pkg::*;

  logic out_stall;
  logic [2*DRIVE_W-1:0] drive_seen;

  assign out_stall  = out_valid && !out_ready;
  assign drive_seen = {left_drive, right_drive};

  `ASSERT_CLK(a_out_hold, clk, rst, out_stall |=> out_valid, "output beat dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk, rst, out_stall |=> $stable(drive_seen), "stalled beat changed")
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_empty_ready, clk, rst, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind encoder_balance_pid encbal_checker u_encbal_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .left_drive  (left_drive),
  .right_drive (right_drive)
);
